### rtl/core/mcr_pkg.sv
package mcr_pkg;

    localparam int DEF_BUF_DEPTH    = 16;
    localparam int DEF_WAIT_DEPTH   = 16;
    localparam int DEF_PAYLOAD_BITS = 32;
    localparam int DEF_TASK_BITS    = 8;

    localparam int CFG_W  = 5;
    localparam int KIND_W = 2;

    // request kinds carried in tuser
    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_RECV = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] K_DONE    = 2'd0;
    localparam logic [KIND_W-1:0] K_BLOCKED = 2'd1;
    localparam logic [KIND_W-1:0] K_WOKEN   = 2'd2;
    localparam logic [KIND_W-1:0] K_REJECT  = 2'd3;

    // per-queue command from the sequencer
    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_q_cmd;

endpackage

### rtl/core/mcr_queue.sv
module mcr_queue import mcr_pkg::*; #(
    parameter int DEPTH = DEF_WAIT_DEPTH,
    parameter int WIDTH = DEF_PAYLOAD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  t_q_cmd                     i_cmd,
    input  logic [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]           o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    // write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_tail <= bump(r_tail);
            end
            if (i_cmd.pop) begin
                r_head <= bump(r_head);
            end
            if (i_cmd.push && !i_cmd.pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop && !i_cmd.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

### rtl/core/mcr_ctrl.sv
module mcr_ctrl import mcr_pkg::*; #(
    parameter int BUF_DEPTH    = DEF_BUF_DEPTH,
    parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int TASK_BITS    = DEF_TASK_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_wr_en,
    input  logic [CFG_W-1:0]                             i_cfg_wr_data,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  logic [((TASK_BITS+PAYLOAD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    input  logic                                         s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    output logic [((TASK_BITS+PAYLOAD_BITS+7)/8)*8-1:0]  m_axis_tdata,
    output logic [KIND_W-1:0]                            m_axis_tuser,
    output logic                                         m_axis_tlast,
    output t_q_cmd                                       o_ring_cmd,
    output logic                                         o_ring_clear,
    output logic [PAYLOAD_BITS-1:0]                      o_ring_wdata,
    input  logic [PAYLOAD_BITS-1:0]                      i_ring_rdata,
    input  logic [$clog2(BUF_DEPTH+1)-1:0]               i_ring_count,
    output t_q_cmd                                       o_snd_cmd,
    output logic [TASK_BITS+PAYLOAD_BITS-1:0]            o_snd_wdata,
    input  logic [TASK_BITS+PAYLOAD_BITS-1:0]            i_snd_rdata,
    input  logic [$clog2(WAIT_DEPTH+1)-1:0]              i_snd_count,
    output t_q_cmd                                       o_rcv_cmd,
    output logic [TASK_BITS-1:0]                         o_rcv_wdata,
    input  logic [TASK_BITS-1:0]                         i_rcv_rdata,
    input  logic [$clog2(WAIT_DEPTH+1)-1:0]              i_rcv_count
);

    localparam int DATA_W = ((TASK_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int BCNT_W = $clog2(BUF_DEPTH + 1);
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [TASK_BITS-1:0]    who;
        logic [PAYLOAD_BITS-1:0] msg;
        logic                    last;
    } t_res;

    logic                    r_state;
    logic [BCNT_W-1:0]       r_cap;
    logic [BCNT_W-1:0]       n_cap;
    logic                    r_req_recv;
    logic [TASK_BITS-1:0]    r_task;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic                    r_m_valid;
    t_res                    r_m;
    logic                    r_pend_valid;
    t_res                    r_pend;

    logic                    accept;
    logic                    out_free;
    logic                    exec;
    t_res                    res0;
    t_res                    res1;
    logic                    res1_valid;
    logic                    ring_push;
    logic                    ring_pop;
    logic                    snd_push;
    logic                    snd_pop;
    logic                    rcv_push;
    logic                    rcv_pop;
    logic [TASK_BITS-1:0]    s_task;
    logic [PAYLOAD_BITS-1:0] s_data;

    assign accept   = s_axis_tvalid && (r_state == S_IDLE);
    // the second word of a request parks in r_pend until the first is taken
    assign out_free = !r_pend_valid && (!r_m_valid || m_axis_tready);
    assign exec     = (r_state == S_EXEC) && out_free;

    assign s_task = i_snd_rdata[TASK_BITS-1:0];
    assign s_data = i_snd_rdata[TASK_BITS +: PAYLOAD_BITS];

    always_comb begin
        if (32'(i_cfg_wr_data) > 32'(BUF_DEPTH)) begin
            n_cap = BCNT_W'(BUF_DEPTH);
        end else begin
            n_cap = BCNT_W'(i_cfg_wr_data);
        end
    end

    always_comb begin
        res0         = '{kind: K_DONE, who: r_task, msg: '0, last: 1'b1};
        res1         = '{kind: K_WOKEN, who: r_task, msg: '0, last: 1'b1};
        res1_valid   = 1'b0;
        ring_push    = 1'b0;
        ring_pop     = 1'b0;
        snd_push     = 1'b0;
        snd_pop      = 1'b0;
        rcv_push     = 1'b0;
        rcv_pop      = 1'b0;
        o_ring_wdata = r_pay;
        if (r_req_recv == REQ_SEND) begin
            if (i_rcv_count != '0) begin
                // hand the word straight to the oldest waiting receiver
                rcv_pop    = 1'b1;
                res0.last  = 1'b0;
                res1.who   = i_rcv_rdata;
                res1.msg   = r_pay;
                res1_valid = 1'b1;
            end else if (i_ring_count < r_cap) begin
                ring_push = 1'b1;
            end else if (i_snd_count == WCNT_W'(WAIT_DEPTH)) begin
                res0.kind = K_REJECT;
            end else begin
                snd_push  = 1'b1;
                res0.kind = K_BLOCKED;
            end
        end else begin
            if (i_ring_count != '0) begin
                ring_pop = 1'b1;
                res0.msg = i_ring_rdata;
                if (i_snd_count != '0) begin
                    // refill the freed slot from the oldest blocked sender
                    snd_pop      = 1'b1;
                    ring_push    = 1'b1;
                    o_ring_wdata = s_data;
                    res0.last    = 1'b0;
                    res1.who     = s_task;
                    res1_valid   = 1'b1;
                end
            end else if (i_snd_count != '0) begin
                snd_pop    = 1'b1;
                res0.msg   = s_data;
                res0.last  = 1'b0;
                res1.who   = s_task;
                res1_valid = 1'b1;
            end else if (i_rcv_count == WCNT_W'(WAIT_DEPTH)) begin
                res0.kind = K_REJECT;
            end else begin
                rcv_push  = 1'b1;
                res0.kind = K_BLOCKED;
            end
        end
    end

    always_comb begin
        o_ring_cmd.rd   = accept;
        o_ring_cmd.push = exec && ring_push;
        o_ring_cmd.pop  = exec && ring_pop;
        o_snd_cmd.rd    = accept;
        o_snd_cmd.push  = exec && snd_push;
        o_snd_cmd.pop   = exec && snd_pop;
        o_rcv_cmd.rd    = accept;
        o_rcv_cmd.push  = exec && rcv_push;
        o_rcv_cmd.pop   = exec && rcv_pop;
    end

    assign o_ring_clear = i_cfg_wr_en;
    assign o_snd_wdata  = {r_pay, r_task};
    assign o_rcv_wdata  = r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cap        <= '0;
            r_m_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= n_cap;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (exec) begin
                r_m_valid    <= 1'b1;
                r_pend_valid <= res1_valid;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid    <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_recv <= s_axis_tuser;
            r_task     <= s_axis_tdata[TASK_BITS-1:0];
            r_pay      <= s_axis_tdata[TASK_BITS +: PAYLOAD_BITS];
        end
        if (exec) begin
            r_m    <= res0;
            r_pend <= res1;
        end else if (r_m_valid && m_axis_tready && r_pend_valid) begin
            r_m <= r_pend;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = DATA_W'({r_m.msg, r_m.who});
    assign m_axis_tuser  = r_m.kind;
    assign m_axis_tlast  = r_m.last;

endmodule

### rtl/core/message_channel_rendezvous.sv
// Buffered message channel between tasks. Each input word is a send (tuser 0, payload word) or a
// receive (tuser 1) from a task; each produces one or two result words, the requester's
// first and a woken partner's second, the final one marked by tlast. A request is accepted
// while idle, when the heads of the ring buffer and both wait queues are read from their
// synchronous memories, and is then decided, writing back pointers and entries. The next
// request is accepted once that decision is made, while results may still wait on the
// output side; a stalled output holds back the decision, not the acceptance. Writing the
// capacity register empties the ring buffer and keeps the wait queues; a capacity above
// BUF_DEPTH is taken as BUF_DEPTH, and zero makes every transfer a direct rendezvous.
// No clearing pass is needed after reset.
module message_channel_rendezvous import mcr_pkg::*; #(
    parameter int BUF_DEPTH    = DEF_BUF_DEPTH,
    parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int TASK_BITS    = DEF_TASK_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic [CFG_W-1:0]                            i_cfg_wr_data,   // ring capacity
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [((TASK_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_axis_tdata,    // task_id, payload
    input  logic                                        s_axis_tuser,    // req_type
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [((TASK_BITS+PAYLOAD_BITS+7)/8)*8-1:0] m_axis_tdata,    // who, message
    output logic [KIND_W-1:0]                           m_axis_tuser,    // kind
    output logic                                        m_axis_tlast
);

    localparam int BCNT_W = $clog2(BUF_DEPTH + 1);
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

    t_q_cmd                            ring_cmd;
    logic                              ring_clear;
    logic [PAYLOAD_BITS-1:0]           ring_wdata;
    logic [PAYLOAD_BITS-1:0]           ring_rdata;
    logic [BCNT_W-1:0]                 ring_count;
    t_q_cmd                            snd_cmd;
    logic [TASK_BITS+PAYLOAD_BITS-1:0] snd_wdata;
    logic [TASK_BITS+PAYLOAD_BITS-1:0] snd_rdata;
    logic [WCNT_W-1:0]                 snd_count;
    t_q_cmd                            rcv_cmd;
    logic [TASK_BITS-1:0]              rcv_wdata;
    logic [TASK_BITS-1:0]              rcv_rdata;
    logic [WCNT_W-1:0]                 rcv_count;

    mcr_queue #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (PAYLOAD_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (ring_clear),
        .i_cmd   (ring_cmd),
        .i_wdata (ring_wdata),
        .o_rdata (ring_rdata),
        .o_count (ring_count)
    );

    mcr_queue #(
        .DEPTH (WAIT_DEPTH),
        .WIDTH (TASK_BITS + PAYLOAD_BITS)
    ) u_snd_wait (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (1'b0),
        .i_cmd   (snd_cmd),
        .i_wdata (snd_wdata),
        .o_rdata (snd_rdata),
        .o_count (snd_count)
    );

    mcr_queue #(
        .DEPTH (WAIT_DEPTH),
        .WIDTH (TASK_BITS)
    ) u_rcv_wait (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (1'b0),
        .i_cmd   (rcv_cmd),
        .i_wdata (rcv_wdata),
        .o_rdata (rcv_rdata),
        .o_count (rcv_count)
    );

    mcr_ctrl #(
        .BUF_DEPTH    (BUF_DEPTH),
        .WAIT_DEPTH   (WAIT_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .TASK_BITS    (TASK_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_ring_cmd    (ring_cmd),
        .o_ring_clear  (ring_clear),
        .o_ring_wdata  (ring_wdata),
        .i_ring_rdata  (ring_rdata),
        .i_ring_count  (ring_count),
        .o_snd_cmd     (snd_cmd),
        .o_snd_wdata   (snd_wdata),
        .i_snd_rdata   (snd_rdata),
        .i_snd_count   (snd_count),
        .o_rcv_cmd     (rcv_cmd),
        .o_rcv_wdata   (rcv_wdata),
        .i_rcv_rdata   (rcv_rdata),
        .i_rcv_count   (rcv_count)
    );

endmodule

### test/message_channel_rendezvous_test.sv
`timescale 1ns / 1ps

module message_channel_rendezvous_test;
    import mcr_pkg::*;

    localparam int TB_TASK_W  = DEF_TASK_BITS;
    localparam int TB_WORD_W  = DEF_PAYLOAD_BITS;
    localparam int TB_DATA_W  = ((TB_TASK_W + TB_WORD_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYC = 8;

    typedef struct {
        logic                 req_type;
        logic [TB_TASK_W-1:0] task_id;
        logic [TB_WORD_W-1:0] payload;
    } t_chan_req;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [TB_TASK_W-1:0] who;
        logic [TB_WORD_W-1:0] message;
        logic                 last_flag;
    } t_chan_result;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wr_data  = '0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [TB_DATA_W-1:0] s_axis_tdata   = '0;
    logic                 s_axis_tuser   = REQ_SEND;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [TB_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    message_channel_rendezvous u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // channel model: capacity, ring of buffered words, blocked senders and receivers
    int                   chan_capacity;
    logic [TB_WORD_W-1:0] ring_words[$];
    logic [TB_TASK_W-1:0] parked_send_task[$];
    logic [TB_WORD_W-1:0] parked_send_word[$];
    logic [TB_TASK_W-1:0] parked_recv_task[$];

    t_chan_req    req_backlog[$];
    t_chan_result due_results[$];

    int queued_cnt;
    int accepted_cnt;
    int result_cnt;
    int error_cnt;
    int kind_cnt[4];
    int idle_cycles;

    function automatic t_chan_result make_result(logic [KIND_W-1:0] k,
                                                 logic [TB_TASK_W-1:0] w,
                                                 logic [TB_WORD_W-1:0] m, logic l);
        t_chan_result r;
        r.kind      = k;
        r.who       = w;
        r.message   = m;
        r.last_flag = l;
        return r;
    endfunction

    function automatic void add_result(t_chan_result r);
        due_results.push_back(r);
        kind_cnt[r.kind]++;
    endfunction

    // works out the result words of one request and updates the channel model
    function automatic void channel_predict(t_chan_req rq);
        logic [TB_TASK_W-1:0] partner;
        logic [TB_WORD_W-1:0] word;
        if (rq.req_type == REQ_SEND) begin
            if (parked_recv_task.size() > 0) begin
                partner = parked_recv_task.pop_front();
                add_result(make_result(K_DONE, rq.task_id, '0, 1'b0));
                add_result(make_result(K_WOKEN, partner, rq.payload, 1'b1));
            end else if (ring_words.size() < chan_capacity) begin
                ring_words.push_back(rq.payload);
                add_result(make_result(K_DONE, rq.task_id, '0, 1'b1));
            end else if (parked_send_task.size() >= DEF_WAIT_DEPTH) begin
                add_result(make_result(K_REJECT, rq.task_id, '0, 1'b1));
            end else begin
                parked_send_task.push_back(rq.task_id);
                parked_send_word.push_back(rq.payload);
                add_result(make_result(K_BLOCKED, rq.task_id, '0, 1'b1));
            end
        end else begin
            if (ring_words.size() > 0) begin
                word = ring_words.pop_front();
                if (parked_send_task.size() > 0) begin
                    partner = parked_send_task.pop_front();
                    ring_words.push_back(parked_send_word.pop_front());
                    add_result(make_result(K_DONE, rq.task_id, word, 1'b0));
                    add_result(make_result(K_WOKEN, partner, '0, 1'b1));
                end else begin
                    add_result(make_result(K_DONE, rq.task_id, word, 1'b1));
                end
            end else if (parked_send_task.size() > 0) begin
                // nothing buffered: take straight from the oldest blocked sender
                partner = parked_send_task.pop_front();
                word    = parked_send_word.pop_front();
                add_result(make_result(K_DONE, rq.task_id, word, 1'b0));
                add_result(make_result(K_WOKEN, partner, '0, 1'b1));
            end else if (parked_recv_task.size() >= DEF_WAIT_DEPTH) begin
                add_result(make_result(K_REJECT, rq.task_id, '0, 1'b1));
            end else begin
                parked_recv_task.push_back(rq.task_id);
                add_result(make_result(K_BLOCKED, rq.task_id, '0, 1'b1));
            end
        end
    endfunction

    task automatic report_mismatch(string field, logic [TB_WORD_W-1:0] got,
                                   logic [TB_WORD_W-1:0] want);
        $display("mismatch at result word %0d: %s got %h want %h", result_cnt, field, got, want);
        error_cnt++;
    endtask

    // driver: bursts of words with random gaps in between
    t_chan_req on_bus;
    int        burst_left = 1;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                channel_predict(on_bus);
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    on_bus = req_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {on_bus.payload, on_bus.task_id};
                    s_axis_tuser  <= on_bus.req_type;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: segments of full readiness, hard stalls and random toggling
    int rdy_mode = 0;
    int rdy_left = 0;

    always @(posedge i_clk) begin
        if (rdy_left <= 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = (rdy_mode == 1) ? $urandom_range(1, 8) : $urandom_range(1, 40);
        end
        rdy_left--;
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'b0;
            default: m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // monitor
    t_chan_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected word, who/message",
                                TB_WORD_W'(m_axis_tdata[TB_TASK_W-1:0]),
                                m_axis_tdata[TB_TASK_W+TB_WORD_W-1:TB_TASK_W]);
            end else begin
                want = due_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", TB_WORD_W'(m_axis_tuser), TB_WORD_W'(want.kind));
                if (m_axis_tdata[TB_TASK_W-1:0] !== want.who)
                    report_mismatch("who", TB_WORD_W'(m_axis_tdata[TB_TASK_W-1:0]),
                                    TB_WORD_W'(want.who));
                if (m_axis_tdata[TB_TASK_W+TB_WORD_W-1:TB_TASK_W] !== want.message)
                    report_mismatch("message", m_axis_tdata[TB_TASK_W+TB_WORD_W-1:TB_TASK_W],
                                    want.message);
                if (m_axis_tlast !== want.last_flag)
                    report_mismatch("last", TB_WORD_W'(m_axis_tlast),
                                    TB_WORD_W'(want.last_flag));
            end
            result_cnt++;
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress, %0d result words still due", due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_req(logic kind_sel, logic [TB_TASK_W-1:0] id,
                            logic [TB_WORD_W-1:0] word);
        t_chan_req rq;
        rq.req_type = kind_sel;
        rq.task_id  = id;
        rq.payload  = word;
        req_backlog.push_back(rq);
        queued_cnt++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_cnt != queued_cnt || due_results.size() != 0);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        chan_capacity = (value > DEF_BUF_DEPTH) ? DEF_BUF_DEPTH : int'(value);
        ring_words.delete();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // runs of same-kind requests so that the ring and both wait queues fill and drain
    task automatic queue_random(int count);
        int   made;
        int   run_len;
        logic run_kind;
        logic [TB_TASK_W-1:0] id;
        logic [TB_WORD_W-1:0] word;
        made = 0;
        while (made < count) begin
            run_len  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : 1;
            run_kind = 1'($urandom_range(0, 1));
            for (int j = 0; j < run_len && made < count; j++) begin
                case ($urandom_range(0, 9))
                    0: id = '0;
                    1: id = '1;
                    default: id = TB_TASK_W'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0: word = '0;
                    1: word = '1;
                    default: word = TB_WORD_W'($urandom);
                endcase
                push_req((run_len == 1) ? logic'($urandom_range(0, 1)) : run_kind, id, word);
                made++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_capacity(0);
        // rendezvous: receiver waits, then sender waits
        push_req(REQ_RECV, 8'h00, 32'h0000_0000);
        push_req(REQ_SEND, 8'hFF, 32'hFFFF_FFFF);
        push_req(REQ_SEND, 8'h12, 32'h0000_0000);
        push_req(REQ_RECV, 8'h34, 32'h0000_0000);
        // payload of a receive is ignored
        push_req(REQ_RECV, 8'h80, 32'hA5A5_A5A5);
        push_req(REQ_SEND, 8'h01, 32'h5A5A_5A5A);
        // fill the sender wait queue, one more gets rejected
        for (int i = 0; i <= DEF_WAIT_DEPTH; i++)
            push_req(REQ_SEND, TB_TASK_W'(32'h40 + i),
                     {8'($urandom_range(0, 255)), 24'h00_C0DE} ^ TB_WORD_W'(i));
        // capacity above depth saturates, ring is emptied, blocked senders stay
        write_capacity(31);
        push_req(REQ_RECV, 8'h77, 32'h0);
        push_req(REQ_SEND, 8'h78, 32'h1234_5678);
        push_req(REQ_RECV, 8'h79, 32'h0);

        write_capacity(16);
        queue_random(75);
        write_capacity(0);
        queue_random(40);
        wait_drained();
        queue_random(35);
        write_capacity(1);
        queue_random(75);
        write_capacity(17);
        queue_random(75);
        write_capacity(CFG_W'($urandom_range(0, 31)));
        queue_random(75);
        write_capacity(5);
        queue_random(75);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("%0d requests through capacities 0, 1, 5, 16 and saturating writes",
                 accepted_cnt);
        $display("%0d result words: done %0d, blocked %0d, woken %0d, rejected %0d",
                 result_cnt, kind_cnt[K_DONE], kind_cnt[K_BLOCKED], kind_cnt[K_WOKEN],
                 kind_cnt[K_REJECT]);
        if (error_cnt == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### message_channel_rendezvous.f
rtl/core/mcr_pkg.sv
rtl/core/mcr_queue.sv
rtl/core/mcr_ctrl.sv
rtl/core/message_channel_rendezvous.sv
test/message_channel_rendezvous_test.sv
